// ===== src/session_slot_table_top_defines.svh =====
// Assertion macros shared by the session slot table RTL.
// Assertions compile away when SYNTHESIS is defined.
`ifndef SESSION_SLOT_TABLE_TOP_DEFINES_SVH
`define SESSION_SLOT_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked assertion, disabled while reset is asserted.
`define SST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define SST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SST_ASSERT(lbl, prop, msg)
`define SST_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/sst_pkg.sv =====
// Package for the session slot table: widths, status codes, register map.
// Used by the channel interfaces and by the top level.
`default_nettype none

package sst_pkg;

    // Field widths.
    localparam int ID_W     = 32;
    localparam int MAX_W    = 7;
    localparam int STATUS_W = 3;

    // Default slot count of the table.
    localparam int SLOTS_DEFAULT = 64;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_SLOT_LIMIT = 1'b0;
    localparam logic REG_ENABLE     = 1'b1;
    localparam logic [MAX_W-1:0] SLOT_LIMIT_RESET = 7'd64;

    // Operation codes.
    localparam logic OP_OPEN  = 1'b0;
    localparam logic OP_CLOSE = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_RUNNING = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO_ID     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd4;

endpackage

`default_nettype wire

// ===== src/sst_if.sv =====
// Valid/ready channel interfaces for the session slot table requests and results.
// Depends on sst_pkg for the field widths.
`default_nettype none

interface sst_req_if;
    import sst_pkg::*;

    logic            valid;
    logic            ready;
    logic            opcode;
    logic [ID_W-1:0] close_id;

    modport source (output valid, output opcode, output close_id, input ready);
    modport sink (input valid, input opcode, input close_id, output ready);
endinterface

interface sst_rsp_if;
    import sst_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     new_id;
    logic [MAX_W-1:0]    active_count;
    logic                error_seen;

    modport source (output valid, output status, output new_id, output active_count,
                    output error_seen, input ready);
    modport sink (input valid, input status, input new_id, input active_count,
                  input error_seen, output ready);
endinterface

`default_nettype wire

// ===== src/session_slot_table_top.sv =====
// Session slot table: one request at a time; the slot walk reads a memory entry per cycle.
// Handling: a request rejected without a walk passes through the result state into the
// output register; an open or close that walks reads up to min(slot limit, SLOTS) slots (one
// slot read per cycle), and the result waits while the previous result still waits for rsp.ready.
// Throughput: the next request is taken the cycle after the result is loaded.
// Reset: asynchronous; afterwards a clearing pass over the min(SLOTS, 128) slots empties the
// slot memory, during which no request is taken (configuration writes are accepted).
`default_nettype none
`include "session_slot_table_top_defines.svh"

module session_slot_table_top #(
    parameter int SLOTS = sst_pkg::SLOTS_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    sst_req_if.sink                          req,
    sst_rsp_if.source                        rsp,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sst_pkg::PADDR_W-1:0] paddr,
    input  wire logic [sst_pkg::PDATA_W-1:0] pwdata,
    output logic      [sst_pkg::PDATA_W-1:0] prdata,
    output logic                             pready
);
    import sst_pkg::*;

    // Only the first 2^MAX_W - 1 slots can ever be addressed by the slot limit.
    localparam int MAX_SLOTS = 2 ** MAX_W;
    localparam int USED  = (SLOTS < MAX_SLOTS) ? SLOTS : MAX_SLOTS;
    localparam int IDX_W = (USED > 1) ? $clog2(USED) : 1;
    localparam int CNT_W = $clog2(USED + 1);
    localparam int CMP_W = (CNT_W > MAX_W) ? CNT_W : MAX_W;

    // Controller states.
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [IDX_W-1:0]    clr_idx_reg, clr_idx_next;
    logic                op_reg, op_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic [ID_W:0]       rd_data_reg;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ID_W-1:0]     res_new_id_reg, res_new_id_next;
    logic [ID_W-1:0]     next_id_reg, next_id_next;
    logic [MAX_W-1:0]    active_total_reg, active_total_next;
    logic                error_reg, error_next;
    logic [MAX_W-1:0]    slot_limit_reg;
    logic                enable_reg;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [ID_W-1:0]     out_new_id_reg, out_new_id_next;
    logic [MAX_W-1:0]    out_count_reg, out_count_next;
    logic                out_error_reg, out_error_next;

    // Slot memory: bit ID_W is the active mark, the rest the identifier.
    logic [ID_W:0]       slot_mem [USED];
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [ID_W:0]       mem_wdata;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_raddr;

    logic [CMP_W-1:0]    lim_wide;
    logic [CNT_W-1:0]    lim;
    logic                req_xfer;
    logic                hit;
    logic                last;
    logic                cfg_wr;

    // Number of slots in use, clamped to the table size.
    always_comb
    begin
        lim_wide = (CMP_W'(slot_limit_reg) > CMP_W'(USED)) ? CMP_W'(USED)
                                                             : CMP_W'(slot_limit_reg);
        lim = lim_wide[CNT_W-1:0];
    end

    assign req_xfer = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    // Check of the entry read in the previous cycle.
    always_comb
    begin
        if (op_reg == OP_OPEN)
        begin
            hit = chk_vld_reg && !rd_data_reg[ID_W];
        end
        else
        begin
            hit = chk_vld_reg && rd_data_reg[ID_W] && (rd_data_reg[ID_W-1:0] == id_reg);
        end
        last = chk_vld_reg && ((CNT_W'(chk_idx_reg) + CNT_W'(1)) == lim);
    end

    // Controller: clearing pass, request decode, slot walk and result hand-off.
    always_comb
    begin
        state_next        = state_reg;
        clr_idx_next      = clr_idx_reg;
        op_next           = op_reg;
        id_next           = id_reg;
        scan_idx_next     = scan_idx_reg;
        chk_vld_next      = 1'b0;
        chk_idx_next      = chk_idx_reg;
        res_status_next   = res_status_reg;
        res_new_id_next   = res_new_id_reg;
        next_id_next      = next_id_reg;
        active_total_next = active_total_reg;
        error_next        = error_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        out_status_next   = out_status_reg;
        out_new_id_next   = out_new_id_reg;
        out_count_next    = out_count_reg;
        out_error_next    = out_error_reg;
        mem_we            = 1'b0;
        mem_waddr         = clr_idx_reg;
        mem_wdata         = '0;
        mem_re            = 1'b0;
        mem_raddr         = scan_idx_reg[IDX_W-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = '0;
                if (CNT_W'(clr_idx_reg) == CNT_W'(USED - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + IDX_W'(1);
                end
            end

            S_IDLE:
            begin
                if (req_xfer)
                begin
                    op_next         = req.opcode;
                    id_next         = req.close_id;
                    scan_idx_next   = '0;
                    res_new_id_next = '0;
                    state_next      = S_DONE;
                    error_next      = 1'b1;
                    if (!enable_reg)
                    begin
                        res_status_next = ST_NOT_RUNNING;
                    end
                    else if (req.opcode == OP_OPEN)
                    begin
                        if (CMP_W'(active_total_reg) >= CMP_W'(lim))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                            error_next = error_reg;
                        end
                    end
                    else if (req.close_id == '0)
                    begin
                        res_status_next = ST_ZERO_ID;
                    end
                    else if (lim == '0)
                    begin
                        res_status_next = ST_NOT_FOUND;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                        error_next = error_reg;
                    end
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    // Update the matching slot and the counters.
                    mem_we          = 1'b1;
                    mem_waddr       = chk_idx_reg;
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                    if (op_reg == OP_OPEN)
                    begin
                        mem_wdata         = {1'b1, next_id_reg};
                        res_new_id_next   = next_id_reg;
                        next_id_next      = next_id_reg + ID_W'(1);
                        active_total_next = active_total_reg + MAX_W'(1);
                    end
                    else
                    begin
                        mem_wdata = {1'b0, id_reg};
                        if (active_total_reg != '0)
                        begin
                            active_total_next = active_total_reg - MAX_W'(1);
                        end
                    end
                end
                else if (last)
                begin
                    res_status_next = (op_reg == OP_OPEN) ? ST_FULL : ST_NOT_FOUND;
                    error_next      = 1'b1;
                    state_next      = S_DONE;
                end
                else if (scan_idx_reg < lim)
                begin
                    // Read the next slot; it is checked in the following cycle.
                    mem_re        = 1'b1;
                    chk_vld_next  = 1'b1;
                    chk_idx_next  = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_new_id_next = res_new_id_reg;
                    out_count_next  = active_total_reg;
                    out_error_next  = error_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_idx_reg      <= '0;
            chk_vld_reg      <= 1'b0;
            next_id_reg      <= ID_W'(1);
            active_total_reg <= '0;
            error_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_idx_reg      <= clr_idx_next;
            chk_vld_reg      <= chk_vld_next;
            next_id_reg      <= next_id_next;
            active_total_reg <= active_total_next;
            error_reg        <= error_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        scan_idx_reg   <= scan_idx_next;
        chk_idx_reg    <= chk_idx_next;
        res_status_reg <= res_status_next;
        res_new_id_reg <= res_new_id_next;
        out_status_reg <= out_status_next;
        out_new_id_reg <= out_new_id_next;
        out_count_reg  <= out_count_next;
        out_error_reg  <= out_error_next;
    end

    // Slot memory with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem[mem_raddr];
        end
    end

    // Configuration registers; a write lands at the access cycle.
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_limit_reg <= SLOT_LIMIT_RESET;
            enable_reg     <= 1'b0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_SLOT_LIMIT)
            begin
                slot_limit_reg <= pwdata[MAX_W-1:0];
            end
            else
            begin
                enable_reg <= pwdata[0];
            end
        end
    end

    // Register read-back; the low address bits are ignored.
    always_comb
    begin
        if (paddr[2] == REG_SLOT_LIMIT)
        begin
            prdata = PDATA_W'(slot_limit_reg);
        end
        else
        begin
            prdata = PDATA_W'(enable_reg);
        end
    end

    // Result channel.
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.new_id       = out_new_id_reg;
    assign rsp.active_count = out_count_reg;
    assign rsp.error_seen   = out_error_reg;

    // A request transfer always leaves the idle state.
    `SST_ASSERT(a_xfer_leaves_idle, req_xfer |=> (state_reg != S_IDLE), "request stayed idle")
    // The slot memory is written only by the clearing pass or by a walk that hit.
    `SST_ASSERT(a_write_source, mem_we |-> ((state_reg == S_CLEAR) || hit), "stray slot write")
    // A new result appears only after the result state.
    `SST_ASSERT(a_result_from_done, $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE),
        "result without completion")
    // The identifier counter advances only on an open that hit.
    `SST_ASSERT(a_next_id_step, !$stable(next_id_reg) |->
        (($past(hit) && ($past(op_reg) == OP_OPEN))), "identifier counter moved")
    // The active count never exceeds the addressable slots.
    `SST_ASSERT_ALWAYS(a_count_bound, CMP_W'(active_total_reg) <= CMP_W'(USED),
        "active count out of range")

endmodule

`default_nettype wire
